// File: rtl/rrwn_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrwn_pkg
// Shared types and codes for the realtime receive window with NACK queue.
// ---------------------------------------------------------------------------
package rrwn_pkg;

   localparam int SEQ_W  = 31;
   localparam int TIME_W = 32;

   localparam logic [SEQ_W-1:0] SEQ_MAX    = 31'h7FFF_FFFF;
   localparam logic [SEQ_W-1:0] HIST_RESET = 31'd1000000;

   // request opcode
   typedef enum logic {
      OP_DATA  = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   // result kind
   typedef enum logic [1:0] {
      KIND_VERDICT = 2'd0,
      KIND_NACK    = 2'd1,
      KIND_EMPTY   = 2'd2
   } kind_type;

   // packet verdict
   typedef enum logic [1:0] {
      VERD_NEW  = 2'd0,
      VERD_LATE = 2'd1,
      VERD_OLD  = 2'd2,
      VERD_DUP  = 2'd3
   } verdict_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DUP,
      ST_AGE_RD,
      ST_AGE_CHK,
      ST_DECIDE,
      ST_MOD,
      ST_FORCE,
      ST_GAP,
      ST_NACK,
      ST_RESP,
      ST_FL_RD,
      ST_FL_LOAD,
      ST_FL_RESP
   } state_type;

endpackage

// File: rtl/realtime_receive_window_nack_unit.sv
`timescale 1ns / 1ps
// An in-order packet passes tail aging (each cell walked is read, then checked), clearing of
// skipped cells, a forced tail move when needed and the queueing of each NACK; a jump of the
// window depth or more first needs a slot reduction (product, remainder, correction). An old
// packet gets its result in the next cycle; a duplicate first checks its cell's received flag.
// A flush hands over each queued NACK after a NACK memory read and a load.
// One request is worked on at a time; the registered cell memory read sets the walk rate.
// Reset is synchronous; then a clearing pass over all WINDOW_DEPTH cells holds req_tready low.
// ---------------------------------------------------------------------------
// realtime_receive_window_nack_unit
// Receive window of one realtime link: classifies packets, ages the tail,
// clears gaps and queues missing numbers as NACKs, flushed on request.
// ---------------------------------------------------------------------------
module realtime_receive_window_nack_unit #(
   parameter int WINDOW_DEPTH  = 64,
   parameter int NACK_CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: history_time_us
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_data,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // seq_num[30:0], now_us[62:31], zero [63]
   input  logic [0:0]  req_tuser,   // opcode[0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // verdict[1:0], nack_seq[32:2], window_head[63:33],
                                    // window_tail[94:64], nack_request[95]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast
);

   import rrwn_pkg::*;

   localparam int SW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW  = $clog2(WINDOW_DEPTH + 1);
   localparam int NW  = (NACK_CAPACITY > 1) ? $clog2(NACK_CAPACITY) : 1;
   localparam int NCW = $clog2(NACK_CAPACITY + 1);

   localparam logic [SEQ_W-1:0] DEPTH_SEQ = SEQ_W'(WINDOW_DEPTH);
   localparam logic [CW-1:0]    DEPTH_CNT = CW'(WINDOW_DEPTH);
   localparam logic [SW:0]      DEPTH_SUM = (SW+1)'(WINDOW_DEPTH);
   localparam logic [SW-1:0]    LAST_SLOT = SW'(WINDOW_DEPTH - 1);
   localparam logic [NCW-1:0]   CAP_CNT   = NCW'(NACK_CAPACITY);
   localparam logic [4:0]       MOD_LAST  = 5'd2;

   // reciprocal of the window depth, scaled by 2^(SEQ_W+SW)
   localparam logic [63:0]      RECIP_WIDE = (64'd1 << (SEQ_W + SW)) / 64'(WINDOW_DEPTH);
   localparam logic [31:0]      RECIP      = RECIP_WIDE[31:0];

   // slot arithmetic modulo the window depth
   function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
      logic [SW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[SW-1:0];
   endfunction

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] a);
      return (a == LAST_SLOT) ? '0 : a + SW'(1);
   endfunction

   // registers
   state_type              state_ff, state_in;
   logic [SEQ_W-1:0]       hist_ff, hist_in;
   logic [SEQ_W-1:0]       head_ff, head_in;
   logic [SEQ_W-1:0]       tail_ff, tail_in;
   logic [SW-1:0]          head_slot_ff, head_slot_in;
   logic [SW-1:0]          tail_slot_ff, tail_slot_in;
   logic [NCW-1:0]         cnt_ff, cnt_in;
   logic [SW-1:0]          ptr_slot_ff, ptr_slot_in;
   logic [SEQ_W-1:0]       ptr_ff, ptr_in;
   logic [SEQ_W-1:0]       seq_ff, seq_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [SW-1:0]          s_slot_ff, s_slot_in;
   logic [CW-1:0]          rem_ff, rem_in;
   logic                   force_ff, force_in;
   logic [NCW-1:0]         fk_ff, fk_in;
   logic [SEQ_W+31:0]      mod_prod_ff, mod_prod_in;
   logic [SEQ_W-1:0]       mod_rem_ff, mod_rem_in;
   logic [4:0]             mod_cnt_ff, mod_cnt_in;
   kind_type               out_kind_ff, out_kind_in;
   verdict_type            out_verdict_ff, out_verdict_in;
   logic [SEQ_W-1:0]       out_nack_ff, out_nack_in;
   logic                   out_req_ff, out_req_in;
   logic                   out_last_ff, out_last_in;

   // memories
   logic [TIME_W:0]        cell_mem [WINDOW_DEPTH];
   logic [TIME_W:0]        cell_rd_ff;
   logic                   cell_we;
   logic [SW-1:0]          cell_waddr;
   logic [TIME_W:0]        cell_wdata;
   logic [SW-1:0]          cell_raddr;
   logic [SEQ_W-1:0]       nack_mem [NACK_CAPACITY];
   logic [SEQ_W-1:0]       nack_rd_ff;
   logic                   nack_we;

   // request fields and shared arithmetic
   logic [SEQ_W-1:0]       in_seq;
   logic [TIME_W-1:0]      in_now;
   logic                   in_flush;
   logic                   req_fire;
   logic                   rsp_fire;
   logic [SEQ_W-1:0]       in_off;
   logic [SW-1:0]          in_slot;
   logic [SEQ_W-1:0]       seq_tail;
   logic [SEQ_W-1:0]       seq_head;
   logic [SEQ_W-1:0]       force_run;
   logic                   force_now;
   logic [CW-1:0]          force_cnt;
   logic [CW-1:0]          gap_cnt;
   logic [TIME_W-1:0]      age_diff;
   logic                   cell_rcv;
   logic                   aged;
   logic [SEQ_W-1:0]       mod_quot;
   logic [SEQ_W-1:0]       mod_fix;
   logic                   nack_done;

   assign in_seq   = req_tdata[30:0];
   assign in_now   = req_tdata[62:31];
   assign in_flush = (op_type'(req_tuser[0]) == OP_FLUSH);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   assign in_off    = in_seq - tail_ff;
   assign in_slot   = slot_add(tail_slot_ff, in_off[SW-1:0]);
   assign seq_tail  = seq_ff - tail_ff;
   assign seq_head  = seq_ff - head_ff;
   assign force_now = (seq_tail >= DEPTH_SEQ);
   assign force_run = seq_tail - DEPTH_SEQ + SEQ_W'(1);
   assign force_cnt = (force_run > DEPTH_SEQ) ? DEPTH_CNT : CW'(force_run);
   assign gap_cnt   = (seq_head >= DEPTH_SEQ) ? DEPTH_CNT : CW'(seq_head);

   // signed 32-bit age, released only when positive and beyond the history
   assign cell_rcv = cell_rd_ff[TIME_W];
   assign age_diff = now_ff - cell_rd_ff[TIME_W-1:0];
   assign aged     = !age_diff[TIME_W-1] && (age_diff[TIME_W-2:0] > hist_ff);

   // slot of a far number: reciprocal quotient, remainder, one correction
   assign mod_quot = SEQ_W'(mod_prod_ff >> (SEQ_W + SW));
   assign mod_fix  = (mod_rem_ff >= DEPTH_SEQ) ? mod_rem_ff - DEPTH_SEQ : mod_rem_ff;

   assign nack_done = (ptr_ff == seq_ff) || (cnt_ff == CAP_CNT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (ptr_slot_ff == LAST_SLOT) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               priority if (in_flush) begin
                  state_in = (cnt_ff == '0) ? ST_RESP : ST_FL_RD;
               end else if (in_seq < tail_ff) begin
                  state_in = ST_RESP;
               end else if (in_seq < head_ff) begin
                  state_in = ST_DUP;
               end else begin
                  state_in = ST_AGE_RD;
               end
            end
         end
         ST_DUP: begin
            state_in = cell_rcv ? ST_RESP : ST_AGE_RD;
         end
         ST_AGE_RD: begin
            state_in = (ptr_ff >= head_ff) ? ST_DECIDE : ST_AGE_CHK;
         end
         ST_AGE_CHK: begin
            state_in = (!cell_rcv || aged) ? ST_AGE_RD : ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (seq_ff >= head_ff) begin
               if (seq_head >= DEPTH_SEQ) begin
                  state_in = ST_MOD;
               end else begin
                  state_in = force_now ? ST_FORCE : ST_GAP;
               end
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_MOD: begin
            if (mod_cnt_ff == MOD_LAST) state_in = force_ff ? ST_FORCE : ST_GAP;
         end
         ST_FORCE: begin
            if (rem_ff == '0) state_in = ST_GAP;
         end
         ST_GAP: begin
            if (rem_ff == '0) state_in = ST_NACK;
         end
         ST_NACK: begin
            if (nack_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_fire) state_in = ST_IDLE;
         end
         ST_FL_RD: begin
            state_in = ST_FL_LOAD;
         end
         ST_FL_LOAD: begin
            state_in = ST_FL_RESP;
         end
         ST_FL_RESP: begin
            if (rsp_fire) state_in = out_last_ff ? ST_IDLE : ST_FL_RD;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // handshakes and memory controls
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cell_we    = 1'b0;
      cell_waddr = ptr_slot_ff;
      cell_wdata = {1'b0, now_ff};
      nack_we    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cell_we = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_AGE_CHK: begin
            cell_we = cell_rcv && aged;
         end
         ST_DECIDE: begin
            // late fill still inside the window after aging
            if ((seq_ff < head_ff) && (seq_ff >= tail_ff)) begin
               cell_we    = 1'b1;
               cell_waddr = s_slot_ff;
               cell_wdata = {1'b1, now_ff};
            end
         end
         ST_FORCE, ST_GAP: begin
            cell_we = (rem_ff != '0);
         end
         ST_NACK: begin
            if (nack_done) begin
               cell_we    = 1'b1;
               cell_waddr = s_slot_ff;
               cell_wdata = {1'b1, now_ff};
            end else begin
               nack_we = 1'b1;
            end
         end
         ST_RESP, ST_FL_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign cell_raddr = (state_ff == ST_IDLE) ? in_slot : ptr_slot_ff;
   assign csr_ready  = 1'b1;

   // datapath next values
   always_comb begin
      hist_in        = hist_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      head_slot_in   = head_slot_ff;
      tail_slot_in   = tail_slot_ff;
      cnt_in         = cnt_ff;
      ptr_slot_in    = ptr_slot_ff;
      ptr_in         = ptr_ff;
      seq_in         = seq_ff;
      now_in         = now_ff;
      s_slot_in      = s_slot_ff;
      rem_in         = rem_ff;
      force_in       = force_ff;
      fk_in          = fk_ff;
      mod_prod_in    = mod_prod_ff;
      mod_rem_in     = mod_rem_ff;
      mod_cnt_in     = mod_cnt_ff;
      out_kind_in    = out_kind_ff;
      out_verdict_in = out_verdict_ff;
      out_nack_in    = out_nack_ff;
      out_req_in     = out_req_ff;
      out_last_in    = out_last_ff;

      if (csr_valid && csr_ready) hist_in = csr_data;

      unique case (state_ff)
         ST_CLEAR: begin
            ptr_slot_in = slot_inc(ptr_slot_ff);
         end
         ST_IDLE: begin
            if (req_fire) begin
               seq_in         = in_seq;
               now_in         = in_now;
               s_slot_in      = in_slot;
               ptr_in         = tail_ff;
               ptr_slot_in    = tail_slot_ff;
               fk_in          = '0;
               out_kind_in    = in_flush ? KIND_EMPTY : KIND_VERDICT;
               out_verdict_in = in_flush ? VERD_NEW : VERD_OLD;
               out_nack_in    = '0;
               out_req_in     = 1'b0;
               out_last_in    = 1'b1;
            end
         end
         ST_DUP: begin
            out_verdict_in = VERD_DUP;
         end
         ST_AGE_CHK: begin
            if (!cell_rcv || aged) begin
               ptr_in      = ptr_ff + SEQ_W'(1);
               ptr_slot_in = slot_inc(ptr_slot_ff);
            end
            if (cell_rcv && aged) begin
               tail_in      = ptr_ff + SEQ_W'(1);
               tail_slot_in = slot_inc(ptr_slot_ff);
            end
         end
         ST_DECIDE: begin
            if (seq_ff >= head_ff) begin
               force_in    = force_now;
               s_slot_in   = slot_add(head_slot_ff, seq_head[SW-1:0]);
               rem_in      = force_now ? force_cnt : gap_cnt;
               ptr_slot_in = force_now ? tail_slot_ff : head_slot_ff;
               ptr_in      = head_ff;
               mod_cnt_in  = '0;
            end else begin
               out_verdict_in = (seq_ff < tail_ff) ? VERD_OLD : VERD_LATE;
            end
         end
         ST_MOD: begin
            mod_cnt_in = mod_cnt_ff + 5'd1;
            if (mod_cnt_ff == 5'd0) begin
               mod_prod_in = (SEQ_W+32)'(seq_ff) * (SEQ_W+32)'(RECIP);
            end
            if (mod_cnt_ff == 5'd1) begin
               mod_rem_in = seq_ff - mod_quot * DEPTH_SEQ;
            end
            if (mod_cnt_ff == MOD_LAST) s_slot_in = mod_fix[SW-1:0];
         end
         ST_FORCE: begin
            if (rem_ff == '0) begin
               rem_in      = gap_cnt;
               ptr_slot_in = head_slot_ff;
            end else begin
               rem_in      = rem_ff - CW'(1);
               ptr_slot_in = slot_inc(ptr_slot_ff);
            end
         end
         ST_GAP: begin
            if (rem_ff != '0) begin
               rem_in      = rem_ff - CW'(1);
               ptr_slot_in = slot_inc(ptr_slot_ff);
            end
         end
         ST_NACK: begin
            if (nack_done) begin
               // commit the new packet
               if (seq_ff < SEQ_MAX) begin
                  head_in      = seq_ff + SEQ_W'(1);
                  head_slot_in = slot_inc(s_slot_ff);
               end else begin
                  head_in      = SEQ_MAX;
                  head_slot_in = s_slot_ff;
               end
               if (force_ff) begin
                  tail_in      = seq_ff - DEPTH_SEQ + SEQ_W'(1);
                  tail_slot_in = slot_inc(s_slot_ff);
               end
               out_verdict_in = VERD_NEW;
               out_req_in     = (cnt_ff != '0);
            end else begin
               cnt_in = cnt_ff + NCW'(1);
               ptr_in = ptr_ff + SEQ_W'(1);
            end
         end
         ST_FL_LOAD: begin
            out_kind_in    = KIND_NACK;
            out_verdict_in = VERD_NEW;
            out_nack_in    = nack_rd_ff;
            out_req_in     = 1'b0;
            out_last_in    = (fk_ff + NCW'(1) == cnt_ff);
         end
         ST_FL_RESP: begin
            if (rsp_fire) begin
               if (out_last_ff) cnt_in = '0;
               else             fk_in  = fk_ff + NCW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         hist_ff      <= HIST_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         head_slot_ff <= '0;
         tail_slot_ff <= '0;
         cnt_ff       <= '0;
         ptr_slot_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         hist_ff      <= hist_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         head_slot_ff <= head_slot_in;
         tail_slot_ff <= tail_slot_in;
         cnt_ff       <= cnt_in;
         ptr_slot_ff  <= ptr_slot_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      seq_ff         <= seq_in;
      now_ff         <= now_in;
      s_slot_ff      <= s_slot_in;
      rem_ff         <= rem_in;
      force_ff       <= force_in;
      fk_ff          <= fk_in;
      mod_prod_ff    <= mod_prod_in;
      mod_rem_ff     <= mod_rem_in;
      mod_cnt_ff     <= mod_cnt_in;
      out_kind_ff    <= out_kind_in;
      out_verdict_ff <= out_verdict_in;
      out_nack_ff    <= out_nack_in;
      out_req_ff     <= out_req_in;
      out_last_ff    <= out_last_in;
   end

   // cell memory: received flag and arrival time
   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   // nack list memory
   always_ff @(posedge clock) begin
      if (nack_we) nack_mem[cnt_ff[NW-1:0]] <= ptr_ff;
      nack_rd_ff <= nack_mem[fk_ff[NW-1:0]];
   end

   // result port
   assign rsp_tdata = {out_req_ff, tail_ff, head_ff, out_nack_ff, out_verdict_ff};
   assign rsp_tuser = out_kind_ff;
   assign rsp_tlast = out_last_ff;

`ifndef SYNTHESIS
   a_window_span: assert property (@(posedge clock) disable iff (reset)
      (head_ff >= tail_ff) && ((head_ff - tail_ff) <= DEPTH_SEQ))
      else $error("window span out of range");

   a_nack_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAP_CNT)
      else $error("nack count above capacity");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a result is pending");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FL_RESP) && rsp_fire && rsp_tlast |=> (cnt_ff == '0))
      else $error("nack list not emptied after flush");

   a_slots: assert property (@(posedge clock) disable iff (reset)
      (head_slot_ff <= LAST_SLOT) && (tail_slot_ff <= LAST_SLOT))
      else $error("slot pointer beyond window depth");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the realtime receive window unit: directed and
// random packet and flush requests against a local window model, every
// result checked field by field, with sender and receiver idling phases.
// ---------------------------------------------------------------------------
module tb_top;
   import rrwn_pkg::*;

   localparam int DEPTH    = 64;
   localparam int NACK_CAP = 32;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_LEN = 400;

   typedef struct packed {
      kind_type    kind;
      verdict_type verdict;
      logic [30:0] nack_seq;
      logic [30:0] head;
      logic [30:0] tail;
      logic        nack_req;
      logic        last;
   } window_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [30:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // seq_num[30:0], now_us[62:31], zero [63]
   logic [0:0]  req_tuser = '0;   // opcode[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;        // verdict, nack_seq, window_head, window_tail, nack_request
   logic [1:0]  rsp_tuser;        // kind[1:0]
   logic        rsp_tlast;

   // window model state
   bit          cell_rcv [DEPTH];
   bit   [31:0] cell_tm  [DEPTH];
   bit   [31:0] head_q, tail_q, hist_q;
   bit   [30:0] nack_q [NACK_CAP];
   int          nack_cnt;
   window_result_type pending_results [$];

   int  errors = 0;
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  hold_ask = 0;
   int  hold_seen = 0;
   int  hold_cycles = 0;
   int  quiet_cycles = 0;
   bit [31:0] now_q = 0;

   realtime_receive_window_nack_unit DUT (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   task automatic push_result(kind_type k, verdict_type v, bit [30:0] ns, bit rq, bit lst);
      window_result_type r;
      r.kind = k; r.verdict = v; r.nack_seq = ns;
      r.head = head_q[30:0]; r.tail = tail_q[30:0];
      r.nack_req = rq; r.last = lst;
      pending_results.push_back(r);
   endtask

   // release old received cells at the tail
   task automatic age_window(bit [31:0] now);
      int rounds;
      int steps;
      bit [31:0] i;
      bit [31:0] age;
      bit stop;
      rounds = 0;
      stop = 0;
      while (!stop && tail_q < head_q && rounds <= DEPTH) begin
         i = tail_q;
         steps = 0;
         while (i < head_q && !cell_rcv[i % DEPTH] && steps < DEPTH) begin
            i++;
            steps++;
         end
         if (i >= head_q || !cell_rcv[i % DEPTH]) begin
            stop = 1;
         end else begin
            age = now - cell_tm[i % DEPTH];
            if (age[31] || age <= hist_q) begin
               stop = 1;
            end else begin
               cell_rcv[i % DEPTH] = 0;
               tail_q = i + 1;
               rounds++;
            end
         end
      end
   endtask

   task automatic clear_cells(bit [31:0] first, bit [31:0] count);
      if (count > DEPTH) count = DEPTH;
      for (bit [31:0] k = 0; k < count; k++) cell_rcv[(first + k) % DEPTH] = 0;
   endtask

   // expected results of one accepted request
   task automatic predict_window(op_type op, bit [31:0] s, bit [31:0] now);
      bit [31:0] gap;
      bit [31:0] new_tail;
      verdict_type v;
      bit rq;
      rq = 0;
      if (op == OP_FLUSH) begin
         if (nack_cnt == 0) begin
            push_result(KIND_EMPTY, VERD_NEW, 0, 0, 1);
         end else begin
            for (int k = 0; k < nack_cnt; k++)
               push_result(KIND_NACK, VERD_NEW, nack_q[k], 0, k + 1 == nack_cnt);
            nack_cnt = 0;
         end
         return;
      end
      if (s < tail_q) begin
         push_result(KIND_VERDICT, VERD_OLD, 0, 0, 1);
         return;
      end
      if (s < head_q && cell_rcv[s % DEPTH]) begin
         push_result(KIND_VERDICT, VERD_DUP, 0, 0, 1);
         return;
      end
      age_window(now);
      if (s >= head_q) begin
         if (s - tail_q >= DEPTH) begin
            new_tail = s - DEPTH + 1;
            clear_cells(tail_q, new_tail - tail_q);
            tail_q = new_tail;
         end
         gap = s - head_q;
         clear_cells(head_q, gap);
         for (bit [31:0] k = 0; k < gap && nack_cnt < NACK_CAP; k++) begin
            nack_q[nack_cnt] = head_q[30:0] + k[30:0];
            nack_cnt++;
         end
         rq = nack_cnt > 0;
         head_q = (s < SEQ_MAX) ? s + 1 : SEQ_MAX;
         v = VERD_NEW;
      end else if (s < tail_q) begin
         push_result(KIND_VERDICT, VERD_OLD, 0, 0, 1);
         return;
      end else begin
         v = VERD_LATE;
      end
      cell_rcv[s % DEPTH] = 1;
      cell_tm[s % DEPTH] = now;
      push_result(KIND_VERDICT, v, 0, rq, 1);
   endtask

   // send one request, idling first as the phase asks
   task automatic send_request(op_type op, bit [30:0] s, bit [31:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, now, s};
      do @(posedge clock); while (!req_tready);
      predict_window(op, {1'b0, s}, now);
   endtask

   task automatic pkt(bit [30:0] s, int dt);
      now_q = now_q + dt;
      send_request(OP_DATA, s, now_q);
   endtask

   task automatic flush();
      send_request(OP_FLUSH, 31'($urandom), $urandom);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_history(bit [30:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      hist_q = value;
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // receiver ready, with long hold-off when asked
   always @(posedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen   <= hold_ask;
         hold_cycles <= HOLD_LEN;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= $urandom_range(99) >= rsp_stall_pct;
      end
   end

   // result checker
   always @(posedge clock) begin
      window_result_type w;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report("unexpected result", rsp_tdata[31:0], 0);
         end else begin
            w = pending_results.pop_front();
            if (rsp_tuser != w.kind)          report("kind", rsp_tuser, w.kind);
            if (rsp_tdata[1:0] != w.verdict)  report("verdict", rsp_tdata[1:0], w.verdict);
            if (rsp_tdata[32:2] != w.nack_seq) report("nack_seq", rsp_tdata[32:2], w.nack_seq);
            if (rsp_tdata[63:33] != w.head)   report("window_head", rsp_tdata[63:33], w.head);
            if (rsp_tdata[94:64] != w.tail)   report("window_tail", rsp_tdata[94:64], w.tail);
            if (rsp_tdata[95] != w.nack_req)  report("nack_request", rsp_tdata[95], w.nack_req);
            if (rsp_tlast != w.last)          report("last", rsp_tlast, w.last);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("[realtime_receive_window_nack_unit] ERROR");
         $finish;
      end
   end

   // in-order, gap, late fill, duplicate, flush of list and of empty list
   task automatic test_basic();
      flush();
      pkt(0, 10); pkt(1, 10); pkt(1, 10); pkt(5, 10);
      pkt(3, 10); pkt(3, 10); pkt(2, 10);
      flush(); flush();
   endtask

   // aging with tiny history and time running backwards
   task automatic test_aging();
      write_history(0);
      pkt(8, 5); pkt(10, 5); pkt(12, 5);
      pkt(9, -100);
      pkt(13, 50); pkt(7, 1); pkt(11, 200);
      write_history(SEQ_MAX);
      pkt(20, 7); pkt(16, 3000);
      flush();
   endtask

   // jumps beyond the window, full list, old packets
   task automatic test_jump();
      write_history(HIST_RESET);
      pkt(300, 1); pkt(40, 1); pkt(250, 1); pkt(330, 1);
      flush();
   endtask

   // random mix of packets and flushes
   task automatic test_random(int n);
      int r;
      bit [31:0] s;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if ($urandom_range(9) == 0) now_q = $urandom;
         else now_q = now_q + $urandom_range(3000);
         if (r < 50) begin
            s = (head_q + $urandom_range(3)) & SEQ_MAX;
         end else if (r < 64 && head_q > tail_q) begin
            s = tail_q + $urandom_range(head_q - tail_q - 1);
         end else if (r < 74) begin
            flush();
            continue;
         end else if (r < 80 && tail_q > 0) begin
            s = $urandom_range(tail_q - 1);
         end else if (r < 86) begin
            s = $urandom & SEQ_MAX;
         end else begin
            s = (head_q + $urandom_range(4, 90)) & SEQ_MAX;
         end
         send_request(OP_DATA, s[30:0], now_q);
      end
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      hold_ask = hold_ask + 1;
      test_random(20);
   endtask

   // head saturates at the top of the number space
   task automatic test_top();
      pkt(SEQ_MAX - 3, 1); pkt(SEQ_MAX, 1); pkt(SEQ_MAX, 1); pkt(SEQ_MAX - 1, 1);
      flush();
   endtask

   initial begin
      hist_q = HIST_RESET;
      head_q = 0; tail_q = 0; nack_cnt = 0;
      foreach (cell_rcv[k]) begin
         cell_rcv[k] = 0;
         cell_tm[k] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_basic();
      test_aging();
      test_jump();
      write_history(2000);
      test_random(30);
      send_idle_pct = 70;
      write_history(20000);
      test_random(30);
      send_idle_pct = 0; rsp_stall_pct = 70;
      write_history(SEQ_MAX);
      test_random(30);
      send_idle_pct = 25; rsp_stall_pct = 25;
      write_history(500);
      test_random(30);
      send_idle_pct = 0; rsp_stall_pct = 0;
      test_backpressure();
      test_top();
      wait_drained();
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("[realtime_receive_window_nack_unit] OK");
      else
         $display("[realtime_receive_window_nack_unit] ERROR");
      $finish;
   end

endmodule
